// ----- sv/dosrq_pkg.sv -----
// Package: request codes and the stored record layout of the ring queue.
`default_nettype none
package dosrq_pkg;

  localparam logic [1:0] REQ_ENQ   = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam int PAYLOAD_W = 64;
  localparam int FLAGS_W   = 16;
  localparam int SEQ_W     = 32;
  localparam int COUNT_W   = 6;

  localparam logic [SEQ_W-1:0] SEQ_START = 32'd1;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     seq;
    logic [FLAGS_W-1:0]   flags;
  } dosrq_rec_t;

  typedef struct packed {
    logic done;
    logic accepted;
    logic dropped;
  } dosrq_stat_t;

endpackage
`default_nettype wire

// ----- sv/dosrq_mem.sv -----
// Record store: single write port, single registered read port.
`default_nettype none
module dosrq_mem
  import dosrq_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire dosrq_rec_t    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output dosrq_rec_t         rdata
);

  dosrq_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/dosrq_ctrl.sv -----
// Queue control: pointers, fill count, sequence counter and request sequencer.
`default_nettype none
module dosrq_ctrl
  import dosrq_pkg::*;
#(
  parameter int DEPTH            = 32,
  parameter int DROPPED_FLAG_BIT = 0,
  parameter int AW               = $clog2(DEPTH),
  parameter int CW               = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           req_type,
  input  wire logic [PAYLOAD_W-1:0] payload,
  input  wire logic [FLAGS_W-1:0]   quality_flags,
  output logic                      busy,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output dosrq_rec_t                mem_wdata,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  output dosrq_stat_t               stat,
  output logic [CW-1:0]             fill_count,
  output logic [SEQ_W-1:0]          seq_counter
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam logic [AW-1:0]      LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0]      FULL_CNT  = CW'(DEPTH);
  localparam logic [FLAGS_W-1:0] DROP_MASK = FLAGS_W'(1) << DROPPED_FLAG_BIT;

  logic [1:0]       state, state_next;
  logic [AW-1:0]    write_index, write_index_next;
  logic [AW-1:0]    read_index, read_index_next;
  logic [CW-1:0]    fill_count_next;
  logic [SEQ_W-1:0] seq_counter_next;
  logic             accepted, accepted_next;
  logic             dropped, dropped_next;
  logic             take;
  logic             full;

  assign busy = (state != S_IDLE);
  assign take = start && !busy;
  assign full = (fill_count == FULL_CNT);

  always_comb begin
    state_next       = state;
    write_index_next = write_index;
    read_index_next  = read_index;
    fill_count_next  = fill_count;
    seq_counter_next = seq_counter;
    accepted_next    = accepted;
    dropped_next     = dropped;
    mem_we           = 1'b0;
    mem_wdata        = '{payload: payload, seq: seq_counter, flags: quality_flags};
    case (state)
      S_IDLE: begin
        if (take) begin
          state_next    = S_READ;
          accepted_next = 1'b0;
          dropped_next  = 1'b0;
          case (req_type)
            REQ_ENQ: begin
              if (full) begin
                read_index_next = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
                mem_wdata.flags = quality_flags | DROP_MASK;
                dropped_next    = 1'b1;
              end else begin
                fill_count_next = fill_count + 1'b1;
              end
              mem_we           = 1'b1;
              write_index_next = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
              seq_counter_next = seq_counter + 1'b1;
              accepted_next    = 1'b1;
            end
            REQ_POP: begin
              if (fill_count != '0) begin
                read_index_next = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
                fill_count_next = fill_count - 1'b1;
                accepted_next   = 1'b1;
              end
            end
            REQ_CLEAR: begin
              write_index_next = '0;
              read_index_next  = '0;
              fill_count_next  = '0;
              seq_counter_next = SEQ_START;
              accepted_next    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ:  state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_index <= '0;
      read_index  <= '0;
      fill_count  <= '0;
      seq_counter <= SEQ_START;
      accepted    <= 1'b0;
      dropped     <= 1'b0;
    end else begin
      state       <= state_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
      fill_count  <= fill_count_next;
      seq_counter <= seq_counter_next;
      accepted    <= accepted_next;
      dropped     <= dropped_next;
    end
  end

  assign mem_waddr = write_index;
  assign mem_re    = (state == S_READ);
  assign mem_raddr = read_index;

  assign stat = '{done: (state == S_OUT), accepted: accepted, dropped: dropped};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_CNT)
    else $error("fill count above depth");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> busy && !stat.done ##1 stat.done)
    else $error("request sequencing broken");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (take && req_type == REQ_POP && fill_count == '0)
      |=> !accepted && fill_count == '0 && $stable(read_index))
    else $error("pop on empty queue changed state");

  a_enq_seq: assert property (@(posedge clk) disable iff (rst)
    (take && req_type == REQ_ENQ) |=> seq_counter == $past(seq_counter) + 32'd1)
    else $error("enqueue did not advance sequence");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (take && req_type == REQ_ENQ) |=> dropped == $past(full) && fill_count != '0)
    else $error("drop flag does not match full queue");

endmodule
`default_nettype wire

// ----- sv/drop_oldest_sequenced_ring_queue_top.sv -----
// Top level: drop-oldest ring queue with sequence stamping and front peek.
//
//  channel   handshake            fields
//  request   start / busy         req_type, payload, quality_flags
//  result    done (one cycle)     accepted, dropped_oldest, front_valid, front_seq,
//                                 front_flags, front_payload, queue_count,
//                                 next_seq_number
//
// A request runs as a sequence: update pointers and write the store, read the front
// entry from the store (registered read port), then present the result with done.
// busy is high in the read and result states after a transfer; a new request is taken
// in the cycle after done. Reset empties the queue and sets the sequence counter to 1;
// store contents are not cleared. The receiver cannot stall; done lasts one cycle.
`default_nettype none
module drop_oldest_sequenced_ring_queue_top
  import dosrq_pkg::*;
#(
  parameter int DEPTH            = 32,
  parameter int DROPPED_FLAG_BIT = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           req_type,
  input  wire logic [PAYLOAD_W-1:0] payload,
  input  wire logic [FLAGS_W-1:0]   quality_flags,
  output logic                      done,
  output logic                      accepted,
  output logic                      dropped_oldest,
  output logic                      front_valid,
  output logic [SEQ_W-1:0]          front_seq,
  output logic [FLAGS_W-1:0]        front_flags,
  output logic [PAYLOAD_W-1:0]      front_payload,
  output logic [COUNT_W-1:0]        queue_count,
  output logic [SEQ_W-1:0]          next_seq_number
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  dosrq_rec_t       mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  dosrq_rec_t       mem_rdata;
  dosrq_stat_t      stat;
  logic [CW-1:0]    fill_count;
  logic [SEQ_W-1:0] seq_counter;
  logic [CW+COUNT_W-1:0] count_ext;

  dosrq_ctrl #(
    .DEPTH            (DEPTH),
    .DROPPED_FLAG_BIT (DROPPED_FLAG_BIT)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req_type      (req_type),
    .payload       (payload),
    .quality_flags (quality_flags),
    .busy          (busy),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .stat          (stat),
    .fill_count    (fill_count),
    .seq_counter   (seq_counter)
  );

  dosrq_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign count_ext = (CW + COUNT_W)'(fill_count);

  always_comb begin
    done            = stat.done;
    accepted        = stat.accepted;
    dropped_oldest  = stat.dropped;
    front_valid     = (fill_count != '0);
    front_seq       = front_valid ? mem_rdata.seq     : '0;
    front_flags     = front_valid ? mem_rdata.flags   : '0;
    front_payload   = front_valid ? mem_rdata.payload : '0;
    queue_count     = count_ext[COUNT_W-1:0];
    next_seq_number = seq_counter;
  end

endmodule
`default_nettype wire
